// ===== hw/rtl/assert_macros.svh =====
// assertion helpers for the checker module
// each macro expands to one labeled concurrent assertion, clocked on the
// rising edge and disabled while the active-low reset is asserted
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// general property check
`define TRC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("trc: property violated");

// signal must not change in the cycle after cond
`define TRC_ASSERT_HOLD(label, clk, rst_n, cond, sig) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error("trc: signal changed while held");

`endif

// ===== hw/rtl/trc_pkg.sv =====
// ----------------------------------------------------------------------------
// trc_pkg
// Types and constants shared by the texture recycle cache modules.
// ----------------------------------------------------------------------------
package trc_pkg;

  // field widths
  localparam int unsigned DimW         = 14;
  localparam int unsigned MipW         = 4;
  localparam int unsigned FmtW         = 4;
  localparam int unsigned HandleW      = 16;
  localparam int unsigned CountW       = 5;
  localparam int unsigned LimitW       = 5;

  // default number of slots in the pool
  localparam int unsigned PoolDepthDef = 16;

  // item kinds
  typedef enum logic {
    KindAcquire = 1'b0,
    KindRelease = 1'b1
  } kind_e;

  // input item
  typedef struct packed {
    kind_e               kind;
    logic [DimW-1:0]     width;
    logic [DimW-1:0]     height;
    logic [MipW-1:0]     mip_count;
    logic [FmtW-1:0]     format_code;
    logic [HandleW-1:0]  handle;
  } in_item_t;

  // result item
  typedef struct packed {
    logic                hit;
    logic [HandleW-1:0]  found_handle;
    logic                evicted;
    logic [HandleW-1:0]  evicted_handle;
    logic [CountW-1:0]   entry_count;
  } out_item_t;

  // one slot of the pool: key and handle
  typedef struct packed {
    logic [DimW-1:0]     width;
    logic [DimW-1:0]     height;
    logic [MipW-1:0]     mip_count;
    logic [FmtW-1:0]     format_code;
    logic [HandleW-1:0]  handle;
  } entry_t;

  // slot store access controls
  typedef struct packed {
    logic rd_en;
    logic ent_we;
    logic rank_we;
  } store_ctrl_t;

endpackage

// ===== hw/rtl/trc_store.sv =====
// ----------------------------------------------------------------------------
// trc_store
// Slot memories of the recycle pool: key/handle per slot and age rank per
// slot, one shared write address and one read address with registered data.
// ----------------------------------------------------------------------------
module trc_store
  import trc_pkg::*;
#(
  parameter int unsigned POOL_DEPTH = PoolDepthDef,
  localparam int unsigned AW        = $clog2(POOL_DEPTH)
) (
  input  logic          clk_i,
  input  store_ctrl_t   ctrl_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic [AW-1:0] wr_addr_i,
  input  entry_t        ent_wdata_i,
  input  logic [AW-1:0] rank_wdata_i,
  output entry_t        ent_rdata_o,
  output logic [AW-1:0] rank_rdata_o
);

  entry_t        ent_mem  [POOL_DEPTH];
  logic [AW-1:0] rank_mem [POOL_DEPTH];
  entry_t        ent_rd_q;
  logic [AW-1:0] rank_rd_q;

  // write ports
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ent_we) begin
      ent_mem[wr_addr_i] <= ent_wdata_i;
    end
    if (ctrl_i.rank_we) begin
      rank_mem[wr_addr_i] <= rank_wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      ent_rd_q  <= ent_mem[rd_addr_i];
      rank_rd_q <= rank_mem[rd_addr_i];
    end
  end

  assign ent_rdata_o  = ent_rd_q;
  assign rank_rdata_o = rank_rd_q;

endmodule

// ===== hw/rtl/texture_recycle_cache.sv =====
// ----------------------------------------------------------------------------
// texture_recycle_cache
// Pool of released buffer handles keyed by size, mip count and format.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid_i / in_stall_o / in_item_i): kind 0 acquires the
//   newest entry whose key matches, kind 1 releases a handle as newest entry.
//   out channel (out_valid_o / out_stall_i / out_item_o): one result per item.
//   cfg_we_i / cfg_data_i write the entry limit (0 = pool depth only) while
//   the block is idle.
// Sequence:
//   acquire scans the pool, release walks it and then writes the new entry,
//   then the result goes to the output register. The slot store has a single
//   read port, so every scan over the pool walks one slot per cycle; a hit
//   takes a second walk to close the gap in the age ranks.
//   in_stall_o is high from the transfer until the result is registered.
// Reset empties the pool and clears the limit; no clearing pass is needed.
// A stalled receiver holds the result in the output register, and the block
// waits with the next finished result until that register is free.
// ----------------------------------------------------------------------------
module texture_recycle_cache
  import trc_pkg::*;
#(
  parameter int unsigned POOL_DEPTH = PoolDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // config
  input  logic              cfg_we_i,
  input  logic [LimitW-1:0] cfg_data_i,
  // input items
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_item_i,
  // results
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_item_o
);

  localparam int unsigned AW   = $clog2(POOL_DEPTH);
  localparam int unsigned CW   = $clog2(POOL_DEPTH + 1);
  localparam int unsigned CmpW = (CW > LimitW) ? CW : LimitW;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StFix,
    StRel,
    StIns,
    StDone
  } state_e;

  state_e                 state_q, state_d;
  in_item_t               item_q, item_d;
  logic [CW-1:0]          idx_q, idx_d;
  logic                   pend_q, pend_d;
  logic [AW-1:0]          pend_idx_q, pend_idx_d;
  logic                   have_q, have_d;
  logic [AW-1:0]          best_idx_q, best_idx_d;
  logic [AW-1:0]          best_rank_q, best_rank_d;
  logic [HandleW-1:0]     best_hnd_q, best_hnd_d;
  logic                   evict_q, evict_d;
  logic                   ev_q, ev_d;
  logic [HandleW-1:0]     ev_hnd_q, ev_hnd_d;
  logic                   free_have_q, free_have_d;
  logic [AW-1:0]          free_idx_q, free_idx_d;
  logic [CW-1:0]          held_q, held_d;
  logic [LimitW-1:0]      max_q, max_d;
  logic [POOL_DEPTH-1:0]  valid_q, valid_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_q, out_d;

  store_ctrl_t            st_ctrl;
  logic [AW-1:0]          st_rd_addr;
  logic [AW-1:0]          st_wr_addr;
  entry_t                 st_ent_wdata;
  logic [AW-1:0]          st_rank_wdata;
  entry_t                 ent_rd;
  logic [AW-1:0]          rank_rd;

  logic                   sweep;
  logic                   last;
  logic                   pv;
  logic                   key_eq;
  logic                   drop;
  logic                   over_limit;
  logic                   is_hit;

  trc_store #(
    .POOL_DEPTH(POOL_DEPTH)
  ) u_store (
    .clk_i       (clk_i),
    .ctrl_i      (st_ctrl),
    .rd_addr_i   (st_rd_addr),
    .wr_addr_i   (st_wr_addr),
    .ent_wdata_i (st_ent_wdata),
    .rank_wdata_i(st_rank_wdata),
    .ent_rdata_o (ent_rd),
    .rank_rdata_o(rank_rd)
  );

  // slot walk helpers
  assign sweep  = (state_q == StScan) || (state_q == StFix) || (state_q == StRel);
  assign last   = pend_q && (pend_idx_q == AW'(POOL_DEPTH - 1));
  assign pv     = valid_q[pend_idx_q];
  assign key_eq = (ent_rd.width == item_q.width) && (ent_rd.height == item_q.height) &&
                  (ent_rd.mip_count == item_q.mip_count) &&
                  (ent_rd.format_code == item_q.format_code);
  assign drop   = pv && evict_q && (rank_rd == AW'(held_q - CW'(1)));

  // release plan from the count before the item
  assign over_limit = (max_q != '0) && (CmpW'(held_q) >= CmpW'(max_q));
  assign is_hit     = (item_q.kind == KindAcquire) && have_q;

  // sequencer next state
  always_comb begin
    state_d       = state_q;
    item_d        = item_q;
    idx_d         = idx_q;
    have_d        = have_q;
    best_idx_d    = best_idx_q;
    best_rank_d   = best_rank_q;
    best_hnd_d    = best_hnd_q;
    evict_d       = evict_q;
    ev_d          = ev_q;
    ev_hnd_d      = ev_hnd_q;
    free_have_d   = free_have_q;
    free_idx_d    = free_idx_q;
    held_d        = held_q;
    valid_d       = valid_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q;
    max_d         = cfg_we_i ? cfg_data_i : max_q;

    st_ctrl       = '0;
    st_rd_addr    = idx_q[AW-1:0];
    st_wr_addr    = pend_idx_q;
    st_rank_wdata = rank_rd;
    st_ent_wdata  = '0;

    // read one slot per cycle during a walk
    st_ctrl.rd_en = sweep && (idx_q < CW'(POOL_DEPTH));
    pend_d        = st_ctrl.rd_en;
    pend_idx_d    = idx_q[AW-1:0];
    if (st_ctrl.rd_en) begin
      idx_d = idx_q + CW'(1);
    end

    // output register drains on transfer
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          item_d      = in_item_i;
          idx_d       = '0;
          have_d      = 1'b0;
          ev_d        = 1'b0;
          free_have_d = 1'b0;
          evict_d     = (over_limit || (held_q == CW'(POOL_DEPTH))) && (held_q != '0);
          state_d     = (in_item_i.kind == KindRelease) ? StRel : StScan;
        end
      end

      // find the newest matching slot
      StScan: begin
        if (pend_q && pv && key_eq && (!have_q || (rank_rd < best_rank_q))) begin
          have_d      = 1'b1;
          best_idx_d  = pend_idx_q;
          best_rank_d = rank_rd;
          best_hnd_d  = ent_rd.handle;
        end
        if (last) begin
          idx_d   = '0;
          state_d = have_d ? StFix : StDone;
        end
      end

      // remove the hit slot and close the rank gap
      StFix: begin
        if (pend_q) begin
          if (pend_idx_q == best_idx_q) begin
            valid_d[pend_idx_q] = 1'b0;
          end else if (pv && (rank_rd > best_rank_q)) begin
            st_ctrl.rank_we = 1'b1;
            st_rank_wdata   = rank_rd - AW'(1);
          end
        end
        if (last) begin
          held_d  = held_q - CW'(1);
          state_d = StDone;
        end
      end

      // evict the oldest if needed, age the rest, find a free slot
      StRel: begin
        if (pend_q) begin
          if (drop) begin
            valid_d[pend_idx_q] = 1'b0;
            ev_d                = 1'b1;
            ev_hnd_d            = ent_rd.handle;
          end else if (pv) begin
            st_ctrl.rank_we = 1'b1;
            st_rank_wdata   = rank_rd + AW'(1);
          end
          if ((!pv || drop) && !free_have_q) begin
            free_have_d = 1'b1;
            free_idx_d  = pend_idx_q;
          end
        end
        if (last) begin
          state_d = StIns;
        end
      end

      // write the released handle as newest
      StIns: begin
        st_ctrl.ent_we           = 1'b1;
        st_ctrl.rank_we          = 1'b1;
        st_wr_addr               = free_idx_q;
        st_rank_wdata            = '0;
        st_ent_wdata.width       = item_q.width;
        st_ent_wdata.height      = item_q.height;
        st_ent_wdata.mip_count   = (item_q.mip_count == '0) ? MipW'(1) : item_q.mip_count;
        st_ent_wdata.format_code = item_q.format_code;
        st_ent_wdata.handle      = item_q.handle;
        valid_d[free_idx_q]      = 1'b1;
        held_d                   = ev_q ? held_q : held_q + CW'(1);
        state_d                  = StDone;
      end

      // hand the result to the output register
      StDone: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.hit            = is_hit;
          out_d.found_handle   = is_hit ? best_hnd_q : '0;
          out_d.evicted        = ev_q;
          out_d.evicted_handle = ev_q ? ev_hnd_q : '0;
          out_d.entry_count    = CountW'(held_q);
          out_valid_d          = 1'b1;
          state_d              = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      item_q      <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      pend_idx_q  <= '0;
      have_q      <= 1'b0;
      best_idx_q  <= '0;
      best_rank_q <= '0;
      best_hnd_q  <= '0;
      evict_q     <= 1'b0;
      ev_q        <= 1'b0;
      ev_hnd_q    <= '0;
      free_have_q <= 1'b0;
      free_idx_q  <= '0;
      held_q      <= '0;
      max_q       <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      item_q      <= item_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      pend_idx_q  <= pend_idx_d;
      have_q      <= have_d;
      best_idx_q  <= best_idx_d;
      best_rank_q <= best_rank_d;
      best_hnd_q  <= best_hnd_d;
      evict_q     <= evict_d;
      ev_q        <= ev_d;
      ev_hnd_q    <= ev_hnd_d;
      free_have_q <= free_have_d;
      free_idx_q  <= free_idx_d;
      held_q      <= held_d;
      max_q       <= max_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== hw/rtl/trc_checker.sv =====
// ----------------------------------------------------------------------------
// trc_checker
// Port-level checks for the texture recycle cache, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module trc_checker
  import trc_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  logic hit_and_ev;
  logic handles_ok;

  // flag and handle relations of the result payload
  assign hit_and_ev = out_item_o.hit && out_item_o.evicted;
  assign handles_ok = (out_item_o.hit || (out_item_o.found_handle == '0)) &&
                      (out_item_o.evicted || (out_item_o.evicted_handle == '0));

  // a stalled result stays and holds its payload
  `TRC_ASSERT(a_out_valid_held, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> out_valid_o)
  `TRC_ASSERT_HOLD(a_out_item_held, clk_i, rst_ni, out_valid_o && out_stall_i, out_item_o)

  // block is busy right after an input transfer
  `TRC_ASSERT(a_busy_after_in, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o)

  // a result is never both a hit and an eviction
  `TRC_ASSERT(a_hit_ev_excl, clk_i, rst_ni, out_valid_o |-> !hit_and_ev)

  // handles are zero unless their flag is set
  `TRC_ASSERT(a_handles_zero, clk_i, rst_ni, out_valid_o |-> handles_ok)

endmodule

bind texture_recycle_cache trc_checker u_trc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_item_o (out_item_o)
);
